### rtl/core/dhoat_pkg.sv
// ----------------------------------------------------------------------------
// dhoat_pkg
// Shared types and codes of the double-hashing open-address table.
// ----------------------------------------------------------------------------
`default_nettype none

package dhoat_pkg;

  localparam int unsigned KEY_W     = 64;
  localparam int unsigned IN_PL_W   = 32;
  localparam int unsigned SIZE_W    = 11;
  localparam int unsigned STEP_W    = 10;
  localparam int unsigned CNT_OUT_W = 11;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 11;

  typedef logic [1:0] status_t;
  localparam status_t ST_FREE    = 2'd0;
  localparam status_t ST_LIVE    = 2'd1;
  localparam status_t ST_DELETED = 2'd2;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_LOOKUP = 2'd0;
  localparam kind_t KIND_INSERT = 2'd1;
  localparam kind_t KIND_REMOVE = 2'd2;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_TABLE_SIZE  = 2'd0;
  localparam cfg_idx_t CFG_STEP_MOD    = 2'd1;
  localparam cfg_idx_t CFG_ENTRY_LIMIT = 2'd2;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_MOD   = 7'b0000100,
    S_STEP  = 7'b0001000,
    S_READ  = 7'b0010000,
    S_EVAL  = 7'b0100000,
    S_RESP  = 7'b1000000
  } state_e;

endpackage

`default_nettype wire

### rtl/core/double_hash_open_address_table.sv
// ----------------------------------------------------------------------------
// double_hash_open_address_table
// Open-address hash table with double-hashing probes, held in one
// synchronous memory of status, key and payload words.
// ----------------------------------------------------------------------------
// channel   direction  handshake               payload
// in        input      in_valid_i / in_stall_o  kind_i, key_i, payload_i
// out       output     out_valid_o / out_stall_i
//                      ok_o, found_payload_o, live_count_o, deleted_count_o
// cfg       input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// an item passes through a bit-serial 64-step remainder of the key, a
// 10-step reduction of the probe step, then one memory read per slot
// probed, each evaluated the cycle after its read
// an unknown kind or a full insert skips the probe and goes to S_RESP
// after reset the status field is cleared one entry a cycle, over all
// TABLE_DEPTH entries, with in_stall_o high; one item is in work at a time
// a result waits in the output register while the next item is taken
// ----------------------------------------------------------------------------
`default_nettype none

module double_hash_open_address_table #(
  parameter int unsigned TABLE_DEPTH  = 1024,
  parameter int unsigned PAYLOAD_BITS = 32
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic [1:0]                          kind_i,
  input  wire logic [dhoat_pkg::KEY_W-1:0]         key_i,
  input  wire logic [dhoat_pkg::IN_PL_W-1:0]       payload_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic                                     ok_o,
  output logic [dhoat_pkg::IN_PL_W-1:0]            found_payload_o,
  output logic [dhoat_pkg::CNT_OUT_W-1:0]          live_count_o,
  output logic [dhoat_pkg::CNT_OUT_W-1:0]          deleted_count_o,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [dhoat_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [dhoat_pkg::CFG_DAT_W-1:0]     cfg_data_i
);

  localparam int unsigned AW     = $clog2(TABLE_DEPTH);
  localparam int unsigned CW     = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned PBW    = PAYLOAD_BITS;
  localparam int unsigned WORD_W = 2 + dhoat_pkg::KEY_W + PBW;
  localparam int unsigned SW     = dhoat_pkg::SIZE_W;
  localparam int unsigned TW     = dhoat_pkg::STEP_W;
  localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);

  dhoat_pkg::state_e state_q, state_d;

  logic [SW-1:0]  table_size_q;
  logic [TW-1:0]  step_mod_q;
  logic [SW-1:0]  entry_limit_q;

  dhoat_pkg::kind_t              kind_q, kind_d;
  logic [dhoat_pkg::KEY_W-1:0]   key_q, key_d;
  logic [PBW-1:0]                pl_q, pl_d;
  logic [dhoat_pkg::KEY_W-1:0]   key_sh_q, key_sh_d;
  logic [5:0]                    bit_cnt_q, bit_cnt_d;
  logic [SW-1:0]                 size_q, size_d;
  logic [TW-1:0]                 stepm_q, stepm_d;
  logic [SW-1:0]                 rem_size_q, rem_size_d;
  logic [TW-1:0]                 rem_step_q, rem_step_d;
  logic [TW-1:0]                 step_sh_q, step_sh_d;
  logic [3:0]                    step_cnt_q, step_cnt_d;
  logic [SW-1:0]                 stepr_q, stepr_d;
  logic [SW-1:0]                 start_q, start_d;
  logic [SW-1:0]                 addr_q, addr_d;
  logic [AW-1:0]                 clr_addr_q, clr_addr_d;
  logic [CW-1:0]                 live_q, live_d;
  logic [CW-1:0]                 del_q, del_d;
  logic                          res_ok_q, res_ok_d;
  logic [dhoat_pkg::IN_PL_W-1:0] res_fp_q, res_fp_d;

  logic                              out_valid_q, out_valid_d;
  logic                              ok_q, ok_d;
  logic [dhoat_pkg::IN_PL_W-1:0]     fp_q, fp_d;
  logic [dhoat_pkg::CNT_OUT_W-1:0]   lc_q, lc_d;
  logic [dhoat_pkg::CNT_OUT_W-1:0]   dc_q, dc_d;

  // table memory
  logic [WORD_W-1:0] mem_q [TABLE_DEPTH];
  logic [WORD_W-1:0] rd_q;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [WORD_W-1:0] mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem_q[mem_raddr];
    end
  end

  dhoat_pkg::status_t          rd_st;
  logic [dhoat_pkg::KEY_W-1:0] rd_key;
  logic [PBW-1:0]              rd_pl;
  logic [95:0]                 rd_pl_ext;
  logic [95:0]                 in_pl_ext;

  assign rd_st     = rd_q[WORD_W-1 -: 2];
  assign rd_key    = rd_q[PBW +: dhoat_pkg::KEY_W];
  assign rd_pl     = rd_q[PBW-1:0];
  assign rd_pl_ext = 96'(rd_pl);
  assign in_pl_ext = {64'd0, payload_i};

  // serial remainder steps
  logic [SW:0]   r1n, r1s;
  logic [TW:0]   r2n, r2s;
  logic [SW:0]   r3n, r3s;
  logic [SW:0]   nsum, nsub;
  logic [SW-1:0] next_addr;
  logic          hit_free, hit_key, take_slot;

  assign r1n = {rem_size_q, key_sh_q[dhoat_pkg::KEY_W-1]};
  assign r1s = (r1n >= {1'b0, size_q}) ? r1n - {1'b0, size_q} : r1n;
  assign r2n = {rem_step_q, key_sh_q[dhoat_pkg::KEY_W-1]};
  assign r2s = (r2n >= {1'b0, stepm_q}) ? r2n - {1'b0, stepm_q} : r2n;
  assign r3n = {stepr_q, step_sh_q[TW-1]};
  assign r3s = (r3n >= {1'b0, size_q}) ? r3n - {1'b0, size_q} : r3n;

  assign nsum      = {1'b0, addr_q} + {1'b0, stepr_q};
  assign nsub      = (nsum >= {1'b0, size_q}) ? nsum - {1'b0, size_q} : nsum;
  assign next_addr = nsub[SW-1:0];

  assign hit_free  = (rd_st == dhoat_pkg::ST_FREE);
  assign hit_key   = (rd_st == dhoat_pkg::ST_LIVE) && (rd_key == key_q);
  assign take_slot = (rd_st != dhoat_pkg::ST_LIVE);

  logic out_load;

  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    key_d       = key_q;
    pl_d        = pl_q;
    key_sh_d    = key_sh_q;
    bit_cnt_d   = bit_cnt_q;
    size_d      = size_q;
    stepm_d     = stepm_q;
    rem_size_d  = rem_size_q;
    rem_step_d  = rem_step_q;
    step_sh_d   = step_sh_q;
    step_cnt_d  = step_cnt_q;
    stepr_d     = stepr_q;
    start_d     = start_q;
    addr_d      = addr_q;
    clr_addr_d  = clr_addr_q;
    live_d      = live_q;
    del_d       = del_q;
    res_ok_d    = res_ok_q;
    res_fp_d    = res_fp_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = AW'(addr_q);
    mem_raddr   = AW'(addr_q);
    mem_wdata   = '0;
    out_load    = 1'b0;

    unique case (state_q)
      dhoat_pkg::S_CLEAR: begin
        mem_we     = 1'b1;
        mem_waddr  = clr_addr_q;
        clr_addr_d = clr_addr_q + 1'b1;
        if (clr_addr_q == LAST_ADDR) begin
          state_d = dhoat_pkg::S_IDLE;
        end
      end
      dhoat_pkg::S_IDLE: begin
        if (in_valid_i) begin
          kind_d     = kind_i;
          key_d      = key_i;
          key_sh_d   = key_i;
          pl_d       = in_pl_ext[PBW-1:0];
          bit_cnt_d  = '0;
          rem_size_d = '0;
          rem_step_d = '0;
          res_ok_d   = 1'b0;
          res_fp_d   = '0;
          if (table_size_q == '0) begin
            size_d = SW'(1);
          end else if (32'(table_size_q) > TABLE_DEPTH) begin
            size_d = SW'(TABLE_DEPTH);
          end else begin
            size_d = table_size_q;
          end
          stepm_d = (step_mod_q == '0) ? TW'(1) : step_mod_q;
          if (kind_i == dhoat_pkg::KIND_LOOKUP || kind_i == dhoat_pkg::KIND_REMOVE) begin
            state_d = dhoat_pkg::S_MOD;
          end else if (kind_i == dhoat_pkg::KIND_INSERT &&
                       32'(live_q) < 32'(entry_limit_q)) begin
            state_d = dhoat_pkg::S_MOD;
          end else begin
            state_d = dhoat_pkg::S_RESP;
          end
        end
      end
      dhoat_pkg::S_MOD: begin
        rem_size_d = r1s[SW-1:0];
        rem_step_d = r2s[TW-1:0];
        key_sh_d   = {key_sh_q[dhoat_pkg::KEY_W-2:0], 1'b0};
        bit_cnt_d  = bit_cnt_q + 1'b1;
        if (bit_cnt_q == 6'd63) begin
          step_sh_d  = (r2s[TW-1:0] == '0) ? TW'(1) : r2s[TW-1:0];
          step_cnt_d = '0;
          stepr_d    = '0;
          state_d    = dhoat_pkg::S_STEP;
        end
      end
      dhoat_pkg::S_STEP: begin
        stepr_d    = r3s[SW-1:0];
        step_sh_d  = {step_sh_q[TW-2:0], 1'b0};
        step_cnt_d = step_cnt_q + 1'b1;
        if (step_cnt_q == 4'(TW - 1)) begin
          start_d = rem_size_q;
          addr_d  = rem_size_q;
          state_d = dhoat_pkg::S_READ;
        end
      end
      dhoat_pkg::S_READ: begin
        mem_re  = 1'b1;
        state_d = dhoat_pkg::S_EVAL;
      end
      dhoat_pkg::S_EVAL: begin
        if (kind_q == dhoat_pkg::KIND_INSERT) begin
          if (take_slot) begin
            mem_we    = 1'b1;
            mem_wdata = {dhoat_pkg::ST_LIVE, key_q, pl_q};
            if (rd_st == dhoat_pkg::ST_DELETED && del_q != '0) begin
              del_d = del_q - 1'b1;
            end
            live_d   = live_q + 1'b1;
            res_ok_d = 1'b1;
            state_d  = dhoat_pkg::S_RESP;
          end else if (next_addr == start_q) begin
            state_d = dhoat_pkg::S_RESP;
          end else begin
            addr_d    = next_addr;
            mem_re    = 1'b1;
            mem_raddr = AW'(next_addr);
          end
        end else begin
          if (hit_free) begin
            state_d = dhoat_pkg::S_RESP;
          end else if (hit_key) begin
            res_ok_d = 1'b1;
            if (kind_q == dhoat_pkg::KIND_LOOKUP) begin
              res_fp_d = rd_pl_ext[dhoat_pkg::IN_PL_W-1:0];
            end else begin
              mem_we    = 1'b1;
              mem_wdata = {dhoat_pkg::ST_DELETED, rd_key, rd_pl};
              if (live_q != '0) begin
                live_d = live_q - 1'b1;
              end
              del_d = del_q + 1'b1;
            end
            state_d = dhoat_pkg::S_RESP;
          end else if (next_addr == start_q) begin
            state_d = dhoat_pkg::S_RESP;
          end else begin
            addr_d    = next_addr;
            mem_re    = 1'b1;
            mem_raddr = AW'(next_addr);
          end
        end
      end
      dhoat_pkg::S_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = dhoat_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = dhoat_pkg::S_IDLE;
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    ok_d        = ok_q;
    fp_d        = fp_q;
    lc_d        = lc_q;
    dc_d        = dc_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
      ok_d        = res_ok_q;
      fp_d        = res_fp_q;
      lc_d        = dhoat_pkg::CNT_OUT_W'(live_q);
      dc_d        = dhoat_pkg::CNT_OUT_W'(del_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= dhoat_pkg::S_CLEAR;
      clr_addr_q    <= '0;
      live_q        <= '0;
      del_q         <= '0;
      out_valid_q   <= 1'b0;
      table_size_q  <= SW'(571);
      step_mod_q    <= TW'(569);
      entry_limit_q <= SW'(512);
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      live_q      <= live_d;
      del_q       <= del_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          dhoat_pkg::CFG_TABLE_SIZE:  table_size_q  <= cfg_data_i;
          dhoat_pkg::CFG_STEP_MOD:    step_mod_q    <= cfg_data_i[TW-1:0];
          dhoat_pkg::CFG_ENTRY_LIMIT: entry_limit_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q     <= kind_d;
    key_q      <= key_d;
    pl_q       <= pl_d;
    key_sh_q   <= key_sh_d;
    bit_cnt_q  <= bit_cnt_d;
    size_q     <= size_d;
    stepm_q    <= stepm_d;
    rem_size_q <= rem_size_d;
    rem_step_q <= rem_step_d;
    step_sh_q  <= step_sh_d;
    step_cnt_q <= step_cnt_d;
    stepr_q    <= stepr_d;
    start_q    <= start_d;
    addr_q     <= addr_d;
    res_ok_q   <= res_ok_d;
    res_fp_q   <= res_fp_d;
    ok_q       <= ok_d;
    fp_q       <= fp_d;
    lc_q       <= lc_d;
    dc_q       <= dc_d;
  end

  assign in_stall_o      = (state_q != dhoat_pkg::S_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign out_valid_o     = out_valid_q;
  assign ok_o            = ok_q;
  assign found_payload_o = fp_q;
  assign live_count_o    = lc_q;
  assign deleted_count_o = dc_q;

endmodule

`default_nettype wire

### rtl/core/dhoat_checker.sv
// ----------------------------------------------------------------------------
// dhoat_checker
// Port-level checks of the double-hashing open-address table.
// ----------------------------------------------------------------------------
`default_nettype none

module dhoat_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic        ok_o,
  input wire logic [31:0] found_payload_o,
  input wire logic [10:0] live_count_o,
  input wire logic [10:0] deleted_count_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(ok_o) &&
    $stable(found_payload_o) && $stable(live_count_o) && $stable(deleted_count_o))
    else $error("result changed while stalled");

  // one item in work: the block is busy right after an input transfer
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while an item is in work");

  // a failed operation returns no payload
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !ok_o |-> found_payload_o == 32'd0)
    else $error("payload on a failed operation");

endmodule

bind double_hash_open_address_table dhoat_checker u_dhoat_checker (.*);

`default_nettype wire

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the double-hashing open-address table. Lookup,
// insert and remove requests are driven with random gaps and random output
// back-pressure. Each transfer is run through a local copy of the table
// state and the predicted reply is checked field by field. A short directed
// table comes first, then random phases under several table settings.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

  typedef struct packed {
    logic        ok;
    logic [31:0] fp;
    logic [10:0] live;
    logic [10:0] del;
  } reply_t;

  typedef struct {
    dhoat_pkg::kind_t kind;
    logic [63:0]      key;
    logic [31:0]      pl;
    bit               typed;
    reply_t           want;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  kind_i = '0;
  logic [63:0] key_i = '0;
  logic [31:0] payload_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        ok_o;
  logic [31:0] found_payload_o;
  logic [10:0] live_count_o;
  logic [10:0] deleted_count_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [10:0] cfg_data_i = '0;

  double_hash_open_address_table DUT (.*);

  always #4 clk_i = ~clk_i;

  // local copy of the table
  logic [63:0]        slot_key_m [1024];
  logic [31:0]        slot_pl_m [1024];
  dhoat_pkg::status_t slot_st_m [1024];
  int unsigned live_m, deleted_m;
  int unsigned size_reg, step_reg, limit_reg;

  reply_t      reply_q[$];
  int          errors, checked, sent, hits, cfg_writes;
  bit          quiet, held;
  row_t        rows[16];
  logic [63:0] key_pool[24];

  function automatic reply_t table_apply(dhoat_pkg::kind_t k, logic [63:0] key,
                                         logic [31:0] pl);
    int unsigned sz, start, stp, a, n;
    logic [63:0] m;
    bit          hit;
    reply_t      r;
    sz = (size_reg == 0) ? 1 : ((size_reg > 1024) ? 1024 : size_reg);
    m = (step_reg == 0) ? 64'd1 : 64'(step_reg);
    start = 32'(key % 64'(sz));
    stp = 32'(key % m);
    if (stp == 0) stp = 1;
    r = '0;
    hit = 0;
    a = start;
    if (k == dhoat_pkg::KIND_LOOKUP || k == dhoat_pkg::KIND_REMOVE) begin
      for (n = 0; n < sz; n++) begin
        if (slot_st_m[a] == dhoat_pkg::ST_FREE) break;
        if (slot_st_m[a] == dhoat_pkg::ST_LIVE && slot_key_m[a] == key) begin
          hit = 1;
          break;
        end
        a = (a + stp) % sz;
        if (a == start) break;
      end
      if (hit) begin
        r.ok = 1'b1;
        if (k == dhoat_pkg::KIND_LOOKUP) r.fp = slot_pl_m[a];
        else begin
          slot_st_m[a] = dhoat_pkg::ST_DELETED;
          if (live_m > 0) live_m--;
          deleted_m++;
        end
      end
    end else if (k == dhoat_pkg::KIND_INSERT && live_m < limit_reg) begin
      for (n = 0; n < sz; n++) begin
        if (slot_st_m[a] != dhoat_pkg::ST_LIVE) begin
          if (slot_st_m[a] == dhoat_pkg::ST_DELETED && deleted_m > 0) deleted_m--;
          slot_key_m[a] = key;
          slot_pl_m[a] = pl;
          slot_st_m[a] = dhoat_pkg::ST_LIVE;
          live_m++;
          r.ok = 1'b1;
          break;
        end
        a = (a + stp) % sz;
        if (a == start) break;
      end
    end
    r.live = 11'(live_m);
    r.del = 11'(deleted_m);
    return r;
  endfunction

  task automatic pause_sender();
    int g;
    g = 0;
    if (!quiet) begin
      case ($urandom_range(0, 19))
        0:       g = $urandom_range(20, 80);
        1, 2, 3: g = $urandom_range(1, 3);
        default: g = 0;
      endcase
    end
    @(negedge clk_i) in_valid_i <= 1'b0;
    if (g > 1) repeat (g - 1) @(negedge clk_i);
  endtask

  task automatic send(dhoat_pkg::kind_t k, logic [63:0] key, logic [31:0] pl,
                      bit typed, reply_t want);
    reply_t r;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    kind_i <= k;
    key_i <= key;
    payload_i <= pl;
    do @(posedge clk_i); while (in_stall_o);
    r = table_apply(k, key, pl);
    if (typed) r = want;
    if (r.ok) hits++;
    reply_q.push_back(r);
    sent++;
    pause_sender();
  endtask

  task automatic write_reg(dhoat_pkg::cfg_idx_t idx, int unsigned val);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= 11'(val);
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      dhoat_pkg::CFG_TABLE_SIZE:  size_reg = val & 11'h7ff;
      dhoat_pkg::CFG_STEP_MOD:    step_reg = val & 10'h3ff;
      dhoat_pkg::CFG_ENTRY_LIMIT: limit_reg = val & 11'h7ff;
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk_i) cfg_valid_i <= 1'b0;
  endtask

  task automatic run_phase(int unsigned sz, int unsigned stp, int unsigned lim, int items);
    dhoat_pkg::kind_t k;
    logic [63:0]      key;
    int               p;
    wait (reply_q.size() == 0);
    repeat (10) @(posedge clk_i);
    write_reg(dhoat_pkg::CFG_TABLE_SIZE, sz);
    write_reg(dhoat_pkg::CFG_STEP_MOD, stp);
    write_reg(dhoat_pkg::CFG_ENTRY_LIMIT, lim);
    foreach (key_pool[j]) key_pool[j] = {$urandom, $urandom};
    for (int i = 0; i < items; i++) begin
      if (i % 60 == 0) quiet = ($urandom_range(0, 3) == 0);
      if (sent == 420) wait (reply_q.size() == 0);
      p = $urandom_range(0, 99);
      if (p < 40) k = dhoat_pkg::KIND_INSERT;
      else if (p < 75) k = dhoat_pkg::KIND_LOOKUP;
      else if (p < 95) k = dhoat_pkg::KIND_REMOVE;
      else k = dhoat_pkg::kind_t'(2'd3);
      key = ($urandom_range(0, 9) < 7) ? key_pool[$urandom_range(0, 23)]
                                       : {$urandom, $urandom};
      send(k, key, $urandom, 1'b0, '0);
    end
  endtask

  // receiver back-pressure, with one long hold-off
  initial begin
    int n;
    forever begin
      @(negedge clk_i);
      if (!held && checked >= 150) begin
        held = 1;
        out_stall_i <= 1'b1;
        repeat (600) @(negedge clk_i);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 3);
        out_stall_i <= 1'b1;
        repeat (n - 1) @(negedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    reply_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (reply_q.size() == 0) begin
        $error("reply transfer with nothing expected");
        errors++;
      end else begin
        e = reply_q.pop_front();
        checked++;
        if (ok_o !== e.ok) begin
          $error("ok: expected %0h, got %0h", e.ok, ok_o);
          errors++;
        end
        if (found_payload_o !== e.fp) begin
          $error("found_payload: expected %0h, got %0h", e.fp, found_payload_o);
          errors++;
        end
        if (live_count_o !== e.live) begin
          $error("live_count: expected %0d, got %0d", e.live, live_count_o);
          errors++;
        end
        if (deleted_count_o !== e.del) begin
          $error("deleted_count: expected %0d, got %0d", e.del, deleted_count_o);
          errors++;
        end
      end
    end
  end

  initial begin
    #60000000;
    $display("testbench failed");
    $finish;
  end

  initial begin
    size_reg = 571;
    step_reg = 569;
    limit_reg = 512;
    live_m = 0;
    deleted_m = 0;
    foreach (slot_st_m[i]) slot_st_m[i] = dhoat_pkg::ST_FREE;
    rows[0]  = '{dhoat_pkg::KIND_LOOKUP, 64'd0, 32'd0, 1, '{1'b0, 32'd0, 11'd0, 11'd0}};
    rows[1]  = '{dhoat_pkg::KIND_REMOVE, '1, '1, 1, '{1'b0, 32'd0, 11'd0, 11'd0}};
    rows[2]  = '{dhoat_pkg::kind_t'(2'd3), '1, '1, 1, '{1'b0, 32'd0, 11'd0, 11'd0}};
    rows[3]  = '{dhoat_pkg::KIND_INSERT, 64'd0, '1, 1, '{1'b1, 32'd0, 11'd1, 11'd0}};
    rows[4]  = '{dhoat_pkg::KIND_INSERT, '1, 32'd0, 1, '{1'b1, 32'd0, 11'd2, 11'd0}};
    rows[5]  = '{dhoat_pkg::KIND_LOOKUP, 64'd0, 32'd0, 1,
                 '{1'b1, 32'hffffffff, 11'd2, 11'd0}};
    rows[6]  = '{dhoat_pkg::KIND_LOOKUP, '1, 32'd7, 1, '{1'b1, 32'd0, 11'd2, 11'd0}};
    rows[7]  = '{dhoat_pkg::KIND_INSERT, 64'd0, 32'h5555_5555, 1,
                 '{1'b1, 32'd0, 11'd3, 11'd0}};
    rows[8]  = '{dhoat_pkg::KIND_REMOVE, 64'd0, 32'd0, 1, '{1'b1, 32'd0, 11'd2, 11'd1}};
    rows[9]  = '{dhoat_pkg::KIND_LOOKUP, 64'd0, 32'd0, 0, '0};
    rows[10] = '{dhoat_pkg::KIND_INSERT, 64'd571, 32'haaaa_aaaa, 0, '0};
    rows[11] = '{dhoat_pkg::KIND_INSERT, 64'd324899, 32'h1234_5678, 0, '0};
    rows[12] = '{dhoat_pkg::KIND_LOOKUP, 64'd324899, 32'd0, 0, '0};
    rows[13] = '{dhoat_pkg::KIND_INSERT, 64'haaaa_aaaa_aaaa_aaaa, 32'h5555_aaaa, 0, '0};
    rows[14] = '{dhoat_pkg::KIND_REMOVE, 64'h5555_5555_5555_5555, 32'd0, 0, '0};
    rows[15] = '{dhoat_pkg::kind_t'(2'd3), 64'd571, 32'd1, 0, '0};
    repeat (11) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    foreach (rows[i]) send(rows[i].kind, rows[i].key, rows[i].pl, rows[i].typed, rows[i].want);
    run_phase(5, 3, 1, 40);
    run_phase(5, 3, 1024, 60);
    run_phase(0, 0, 0, 20);
    run_phase(0, 0, 5, 20);
    run_phase(2047, 1023, 2047, 230);
    run_phase(13, 11, 12, 90);
    run_phase(571, 569, 512, 200);
    run_phase(7, 5, 1024, 80);
    run_phase(1024, 1, 300, 80);
    @(negedge clk_i) in_valid_i <= 1'b0;
    wait (reply_q.size() == 0);
    repeat (100) @(posedge clk_i);
    $display("%0d operations sent, %0d replies checked, %0d found or stored",
             sent, checked, hits);
    $display("%0d register writes over nine table settings", cfg_writes);
    if (errors == 0 && reply_q.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

### files.f
rtl/core/dhoat_pkg.sv
rtl/core/double_hash_open_address_table.sv
rtl/core/dhoat_checker.sv
tb/testbench.sv
